// File: src/ric_pkg.sv
package ric_pkg;

	localparam int NUM_SOURCES_DEF    = 64;
	localparam int NUM_HARD_LINES_DEF = 6;

	// field widths of the request and result
	localparam int OP_W     = 3;
	localparam int IDX_W    = 6;
	localparam int WORD_W   = 64;
	localparam int HARD_W   = 6;
	localparam int FOUND_W  = 6;
	localparam int CFG_W    = 32;
	localparam int LINE_W   = 4;
	localparam int CFG_EN   = 31;
	localparam int GRP_W    = 8;

	// packed stream widths, rounded up to whole bytes
	localparam int IN_BITS  = OP_W + IDX_W + WORD_W + WORD_W;
	localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
	localparam int OUT_BITS = WORD_W + HARD_W + 1 + FOUND_W;
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

	typedef enum logic [OP_W-1:0] {
		OP_READ_CFG  = 3'd0,
		OP_WRITE_CFG = 3'd1,
		OP_READ_PEND = 3'd2,
		OP_SET_PEND  = 3'd3,
		OP_CLR_PEND  = 3'd4,
		OP_FIND      = 3'd5
	} op_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic capture;
		logic scan;
		logic load;
	} cmd_t;

endpackage

// File: src/routed_interrupt_controller.sv
// Interrupt controller for NUM_SOURCES sources, each with a config word (enable in
// bit 31, target thread id in 30:8, hard line in 3:0) and a soft pending bit. Each
// request reads or writes a config word, reads the pending vector (soft bits ORed
// with the source_lines sampled in that request), sets or clears soft bits, or finds
// the highest enabled pending source routed to a hard line; every result carries
// hard_irq as it stands after the request's update. One result per request. A
// request passes capture and state update at the accepting edge, a registered scan
// over all sources, and a final priority pick into the output register, which waits
// while the output register holds a result that is not being taken; the next request
// is taken in the cycle the result is loaded, so a request is not accepted before the
// previous result is loaded. Config writes and soft bits take effect from the
// request that carries them.
module routed_interrupt_controller #(
	parameter int NUM_SOURCES    = ric_pkg::NUM_SOURCES_DEF,
	parameter int NUM_HARD_LINES = ric_pkg::NUM_HARD_LINES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	// op, index, write_data, source_lines, zero fill
	input  logic [ric_pkg::IN_W-1:0]  s_tdata,
	output logic                      m_tvalid,
	input  logic                      m_tready,
	// read_data, hard_irq, found_valid, found_source, zero fill
	output logic [ric_pkg::OUT_W-1:0] m_tdata
);

	ric_pkg::cmd_t cmd;

	ric_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd)
	);

	ric_dp #(
		.NUM_SOURCES    (NUM_SOURCES),
		.NUM_HARD_LINES (NUM_HARD_LINES)
	) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.s_tdata (s_tdata),
		.m_tdata (m_tdata)
	);

endmodule

// File: src/ric_ctrl.sv
module ric_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	output ric_pkg::cmd_t  cmd
);

	ric_pkg::state_t state_q, state_d;
	logic            out_valid_q;
	logic            load_ok;

	assign load_ok  = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ric_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		s_tready    = 1'b0;
		cmd.capture = 1'b0;
		cmd.scan    = 1'b0;
		cmd.load    = 1'b0;
		case (state_q)
			ric_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_d     = ric_pkg::ST_SCAN;
				end
			end
			ric_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				state_d  = ric_pkg::ST_DONE;
			end
			ric_pkg::ST_DONE: begin
				// once the output register can take it, the result leaves for it and a new request may come in
				if (load_ok) begin
					cmd.load = 1'b1;
					s_tready = 1'b1;
					if (s_tvalid) begin
						cmd.capture = 1'b1;
						state_d     = ric_pkg::ST_SCAN;
					end else begin
						state_d = ric_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ric_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

endmodule

// File: src/ric_dp.sv
module ric_dp #(
	parameter int NUM_SOURCES    = ric_pkg::NUM_SOURCES_DEF,
	parameter int NUM_HARD_LINES = ric_pkg::NUM_HARD_LINES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  ric_pkg::cmd_t             cmd,
	input  logic [ric_pkg::IN_W-1:0]  s_tdata,
	output logic [ric_pkg::OUT_W-1:0] m_tdata
);

	localparam int SW     = (NUM_SOURCES > 1) ? $clog2(NUM_SOURCES) : 1;
	localparam int NGRP   = (NUM_SOURCES + ric_pkg::GRP_W - 1) / ric_pkg::GRP_W;
	localparam int PAD_N  = NGRP * ric_pkg::GRP_W;
	localparam int POS_W  = $clog2(ric_pkg::GRP_W);
	localparam int HL     = (NUM_HARD_LINES < ric_pkg::HARD_W) ? NUM_HARD_LINES
	                                                           : ric_pkg::HARD_W;

	// request fields
	logic [ric_pkg::OP_W-1:0]   in_op;
	logic [ric_pkg::IDX_W-1:0]  in_idx;
	logic [ric_pkg::WORD_W-1:0] in_wdata;
	logic [ric_pkg::WORD_W-1:0] in_lines;
	logic                       in_rng;
	logic [SW-1:0]              in_addr;

	assign in_op    = s_tdata[ric_pkg::OP_W-1:0];
	assign in_idx   = s_tdata[ric_pkg::OP_W +: ric_pkg::IDX_W];
	assign in_wdata = s_tdata[ric_pkg::OP_W + ric_pkg::IDX_W +: ric_pkg::WORD_W];
	assign in_lines = s_tdata[ric_pkg::OP_W + ric_pkg::IDX_W + ric_pkg::WORD_W +: ric_pkg::WORD_W];
	assign in_rng   = {1'b0, in_idx} < (ric_pkg::IDX_W + 1)'(NUM_SOURCES);
	assign in_addr  = in_idx[SW-1:0];

	// per-source state: full word in memory, enable and line in flops for the scan
	logic [ric_pkg::CFG_W-1:0]  cfg_mem [NUM_SOURCES];
	logic [NUM_SOURCES-1:0]     vld_q;
	logic [NUM_SOURCES-1:0]     en_q;
	logic [ric_pkg::LINE_W-1:0] line_q [NUM_SOURCES];
	logic [NUM_SOURCES-1:0]     soft_q;

	logic [ric_pkg::OP_W-1:0]   op_s1;
	logic [ric_pkg::IDX_W-1:0]  idx_s1;
	logic [NUM_SOURCES-1:0]     lines_s1;
	logic [ric_pkg::CFG_W-1:0]  rd_q;
	logic                       rd_vld_q;

	logic                       cfg_we;

	assign cfg_we = cmd.capture && (in_op == ric_pkg::OP_WRITE_CFG) && in_rng;

	always_ff @(posedge clk) begin
		if (cfg_we) begin
			cfg_mem[in_addr] <= in_wdata[ric_pkg::CFG_W-1:0];
		end
		if (cmd.capture && in_rng) begin
			rd_q <= cfg_mem[in_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			en_q     <= '0;
			soft_q   <= '0;
			rd_vld_q <= 1'b0;
			for (int i = 0; i < NUM_SOURCES; i++) begin
				line_q[i] <= '0;
			end
		end else if (cmd.capture) begin
			rd_vld_q <= in_rng && vld_q[in_addr];
			if (cfg_we) begin
				vld_q[in_addr]  <= 1'b1;
				en_q[in_addr]   <= in_wdata[ric_pkg::CFG_EN];
				line_q[in_addr] <= in_wdata[ric_pkg::LINE_W-1:0];
			end
			case (in_op)
				ric_pkg::OP_SET_PEND: soft_q <= soft_q | in_wdata[NUM_SOURCES-1:0];
				ric_pkg::OP_CLR_PEND: soft_q <= soft_q & ~in_wdata[NUM_SOURCES-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_s1    <= in_op;
			idx_s1   <= in_idx;
			lines_s1 <= in_lines[NUM_SOURCES-1:0];
		end
	end

	// scan over the updated state
	logic [NUM_SOURCES-1:0]  pend;
	logic [NUM_SOURCES-1:0]  act;
	logic [PAD_N-1:0]        match;
	logic [ric_pkg::HARD_W-1:0] hard;
	logic [NGRP-1:0]         grp_hit;
	logic [POS_W-1:0]        grp_pos [NGRP];

	always_comb begin
		pend  = soft_q | lines_s1;
		act   = pend & en_q;
		match = '0;
		hard  = '0;
		for (int i = 0; i < NUM_SOURCES; i++) begin
			// the line field is 4 bits, so a line number of 16 or more never matches
			match[i] = act[i] && (idx_s1[ric_pkg::IDX_W-1:ric_pkg::LINE_W] == '0)
			           && (line_q[i] == idx_s1[ric_pkg::LINE_W-1:0]);
		end
		for (int l = 0; l < HL; l++) begin
			for (int i = 0; i < NUM_SOURCES; i++) begin
				if (act[i] && (line_q[i] == ric_pkg::LINE_W'(l))) begin
					hard[l] = 1'b1;
				end
			end
		end
		for (int g = 0; g < NGRP; g++) begin
			grp_hit[g] = 1'b0;
			grp_pos[g] = '0;
			for (int j = 0; j < ric_pkg::GRP_W; j++) begin
				if (match[g*ric_pkg::GRP_W + j]) begin
					grp_hit[g] = 1'b1;
					grp_pos[g] = POS_W'(j);
				end
			end
		end
	end

	logic [NUM_SOURCES-1:0]     pend_s2;
	logic [ric_pkg::HARD_W-1:0] hard_s2;
	logic [NGRP-1:0]            grp_hit_s2;
	logic [POS_W-1:0]           grp_pos_s2 [NGRP];

	always_ff @(posedge clk) begin
		if (cmd.scan) begin
			pend_s2    <= pend;
			hard_s2    <= hard;
			grp_hit_s2 <= grp_hit;
			for (int g = 0; g < NGRP; g++) begin
				grp_pos_s2[g] <= grp_pos[g];
			end
		end
	end

	// final pick across the groups and result assembly
	logic [ric_pkg::WORD_W-1:0]  rdata;
	logic                        fvalid;
	logic [ric_pkg::FOUND_W-1:0] fsrc;

	always_comb begin
		fvalid = 1'b0;
		fsrc   = '0;
		for (int g = 0; g < NGRP; g++) begin
			if (grp_hit_s2[g]) begin
				fvalid = 1'b1;
				fsrc   = (ric_pkg::FOUND_W'(g) << POS_W) | ric_pkg::FOUND_W'(grp_pos_s2[g]);
			end
		end
		if (op_s1 != ric_pkg::OP_FIND) begin
			fvalid = 1'b0;
			fsrc   = '0;
		end
		case (op_s1)
			ric_pkg::OP_READ_CFG:  rdata = rd_vld_q ? ric_pkg::WORD_W'(rd_q) : '0;
			ric_pkg::OP_READ_PEND: rdata = ric_pkg::WORD_W'(pend_s2);
			default:               rdata = '0;
		endcase
	end

	logic [ric_pkg::OUT_W-1:0] out_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			out_q <= ric_pkg::OUT_W'({fsrc, fvalid, hard_s2, rdata});
		end
	end

	assign m_tdata = out_q;

endmodule

// File: verif/routed_interrupt_controller_tb.sv
module routed_interrupt_controller_tb;

	localparam int NSRC         = ric_pkg::NUM_SOURCES_DEF;
	localparam int NLINES       = ric_pkg::NUM_HARD_LINES_DEF;
	localparam int RANDOM_ITEMS = 1650;
	localparam int MAX_WAIT     = 13;
	localparam int DRAIN_CYCLES = 8;
	localparam int CYCLE_LIMIT  = 300000;

	// op codes the block leaves undefined
	localparam logic [ric_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [ric_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

	// request bit positions in s_tdata
	localparam int IDX_LO   = ric_pkg::OP_W;
	localparam int WDATA_LO = IDX_LO + ric_pkg::IDX_W;
	localparam int LINES_LO = WDATA_LO + ric_pkg::WORD_W;
	// result bit positions in m_tdata
	localparam int HARD_LO  = ric_pkg::WORD_W;
	localparam int FV_BIT   = HARD_LO + ric_pkg::HARD_W;
	localparam int FS_LO    = FV_BIT + 1;

	localparam logic [ric_pkg::WORD_W-1:0] SRC_MASK =
		(NSRC >= 64) ? '1 : ((64'd1 << NSRC) - 64'd1);

	typedef struct packed {
		logic [ric_pkg::OP_W-1:0]   op;
		logic [ric_pkg::IDX_W-1:0]  index;
		logic [ric_pkg::WORD_W-1:0] write_data;
		logic [ric_pkg::WORD_W-1:0] source_lines;
	} request_t;

	typedef struct packed {
		logic [ric_pkg::WORD_W-1:0]  read_data;
		logic [ric_pkg::HARD_W-1:0]  hard_irq;
		logic                        found_valid;
		logic [ric_pkg::FOUND_W-1:0] found_source;
	} response_t;

	typedef struct packed {
		request_t  req;
		logic      typed;
		response_t want;
	} directed_row_t;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       s_tvalid;
	logic                       s_tready;
	logic [ric_pkg::IN_W-1:0]   s_tdata;
	logic                       m_tvalid;
	logic                       m_tready;
	logic [ric_pkg::OUT_W-1:0]  m_tdata;

	logic [ric_pkg::CFG_W-1:0]  cfg_word [NSRC];
	logic [ric_pkg::WORD_W-1:0] soft_pend;
	response_t                  awaited_responses [$];
	directed_row_t              directed_rows [$];
	response_t                  got_rsp;
	response_t                  want_rsp;
	int                         error_count = 0;
	int                         cycle_count;
	bit                         quiet;

	routed_interrupt_controller dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// updates the controller state for one request and returns its result
	function automatic response_t controller_response(request_t r);
		response_t                  rsp;
		logic [ric_pkg::WORD_W-1:0] pend;
		logic [ric_pkg::WORD_W-1:0] act;
		logic [ric_pkg::LINE_W-1:0] line;
		rsp = '0;
		case (r.op)
			ric_pkg::OP_READ_CFG: begin
				if (r.index < NSRC)
					rsp.read_data = {{(ric_pkg::WORD_W-ric_pkg::CFG_W){1'b0}},
						cfg_word[r.index]};
			end
			ric_pkg::OP_WRITE_CFG: begin
				if (r.index < NSRC)
					cfg_word[r.index] = r.write_data[ric_pkg::CFG_W-1:0];
			end
			ric_pkg::OP_SET_PEND: soft_pend = (soft_pend | r.write_data) & SRC_MASK;
			ric_pkg::OP_CLR_PEND: soft_pend = (soft_pend & ~r.write_data) & SRC_MASK;
			default: ;
		endcase
		pend = (soft_pend | r.source_lines) & SRC_MASK;
		act = '0;
		for (int i = 0; i < NSRC; i++)
			act[i] = pend[i] & cfg_word[i][ric_pkg::CFG_EN];
		if (r.op == ric_pkg::OP_READ_PEND)
			rsp.read_data = pend;
		for (int i = 0; i < NSRC; i++) begin
			line = cfg_word[i][ric_pkg::LINE_W-1:0];
			if (act[i]) begin
				if (r.op == ric_pkg::OP_FIND && {2'b00, line} == r.index) begin
					rsp.found_valid = 1'b1;
					rsp.found_source = ric_pkg::FOUND_W'(i);
				end
				if (line < NLINES)
					rsp.hard_irq[line] = 1'b1;
			end
		end
		return rsp;
	endfunction

	function automatic logic [ric_pkg::WORD_W-1:0] sparse_word();
		return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
	endfunction

	task automatic add_row(input logic [ric_pkg::OP_W-1:0] op,
			input logic [ric_pkg::IDX_W-1:0] index,
			input logic [ric_pkg::WORD_W-1:0] wdata, input logic [ric_pkg::WORD_W-1:0] lines,
			input logic typed = 1'b0, input logic [ric_pkg::WORD_W-1:0] rdata = '0,
			input logic fvalid = 1'b0, input logic [ric_pkg::FOUND_W-1:0] fsrc = '0);
		directed_row_t row;
		row.req.op = op;
		row.req.index = index;
		row.req.write_data = wdata;
		row.req.source_lines = lines;
		row.typed = typed;
		row.want.read_data = rdata;
		row.want.hard_irq = '0;
		row.want.found_valid = fvalid;
		row.want.found_source = fsrc;
		directed_rows.push_back(row);
	endtask

	task automatic issue(input request_t r, input logic typed, input response_t want);
		int                       gap;
		logic [ric_pkg::IN_W-1:0] word;
		response_t                predicted;
		gap = quiet ? 0 : $urandom_range(0, MAX_WAIT);
		word = '0;
		word[IDX_LO-1:0] = r.op;
		word[WDATA_LO-1:IDX_LO] = r.index;
		word[LINES_LO-1:WDATA_LO] = r.write_data;
		word[LINES_LO+ric_pkg::WORD_W-1:LINES_LO] = r.source_lines;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= word;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		predicted = controller_response(r);
		awaited_responses.push_back(typed ? want : predicted);
	endtask

	initial begin
		request_t                   rq;
		int                         pick;
		int                         k;
		logic [ric_pkg::LINE_W-1:0] line;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		quiet = 1'b0;
		for (int i = 0; i < NSRC; i++)
			cfg_word[i] = '0;
		soft_pend = '0;

		// after reset everything is disabled
		add_row(ric_pkg::OP_READ_CFG, 0, '0, '0, 1'b1);
		add_row(ric_pkg::OP_READ_PEND, 0, '0, '1, 1'b1, '1);
		add_row(ric_pkg::OP_FIND, 0, '0, '1, 1'b1);
		// source 63 with every config bit set, routed to line 15
		add_row(ric_pkg::OP_WRITE_CFG, 63, '1, '0, 1'b1);
		add_row(ric_pkg::OP_READ_CFG, 63, '0, '0, 1'b1, 64'h0000_0000_ffff_ffff);
		add_row(ric_pkg::OP_FIND, 15, '0, 64'h8000_0000_0000_0000, 1'b1, '0, 1'b1, 6'd63);
		add_row(ric_pkg::OP_WRITE_CFG, 0, 64'h8000_0005, '0);
		add_row(ric_pkg::OP_WRITE_CFG, 10, 64'h80ab_cd02, '0);
		// line past the hard outputs
		add_row(ric_pkg::OP_WRITE_CFG, 5, 64'h8012_3409, '0);
		// disabled source
		add_row(ric_pkg::OP_WRITE_CFG, 1, 64'h0000_0003, '0);
		add_row(ric_pkg::OP_SET_PEND, 0, 64'h0403, '0);
		add_row(ric_pkg::OP_READ_PEND, 0, '0, 64'h20);
		add_row(ric_pkg::OP_FIND, 5, '0, '0);
		add_row(ric_pkg::OP_FIND, 2, '0, '0);
		add_row(ric_pkg::OP_FIND, 9, '0, 64'h20);
		add_row(ric_pkg::OP_FIND, 3, '0, '0);
		// line numbers the 4-bit field cannot hold
		add_row(ric_pkg::OP_FIND, 16, '0, '1);
		add_row(ric_pkg::OP_FIND, 63, '0, '1);
		// upper half of the write word is dropped
		add_row(ric_pkg::OP_WRITE_CFG, 12, 64'hffff_ffff_8000_0002, '0);
		add_row(ric_pkg::OP_READ_CFG, 12, '0, '0);
		add_row(ric_pkg::OP_CLR_PEND, 0, '1, '0);
		add_row(OP_SPARE_6, 63, '1, '0, 1'b1);
		add_row(OP_SPARE_7, 42, '1, '0, 1'b1);
		add_row(ric_pkg::OP_SET_PEND, 0, '1, '0);
		add_row(ric_pkg::OP_READ_PEND, 0, '0, '0);

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_rows[n])
			issue(directed_rows[n].req, directed_rows[n].typed, directed_rows[n].want);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			// now and then a burst with no gaps on either side
			if (n % 40 == 0)
				quiet = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 99);
			rq.index = ric_pkg::IDX_W'($urandom_range(0, 63));
			rq.write_data = {$urandom, $urandom};
			case ($urandom_range(0, 3))
				0: rq.source_lines = '0;
				1: rq.source_lines = 64'd1 << $urandom_range(0, 63);
				2: rq.source_lines = sparse_word();
				default: rq.source_lines = {$urandom, $urandom};
			endcase
			if (pick < 22) begin
				rq.op = ric_pkg::OP_WRITE_CFG;
				// mostly enabled sources on the visible lines
				if ($urandom_range(0, 7) != 0) begin
					line = ($urandom_range(0, 4) == 0) ?
						ric_pkg::LINE_W'($urandom_range(6, 15)) :
						ric_pkg::LINE_W'($urandom_range(0, NLINES - 1));
					rq.write_data[ric_pkg::CFG_EN] = ($urandom_range(0, 9) < 7);
					rq.write_data[ric_pkg::LINE_W-1:0] = line;
				end
			end else if (pick < 36) begin
				rq.op = ric_pkg::OP_READ_CFG;
			end else if (pick < 46) begin
				rq.op = ric_pkg::OP_READ_PEND;
			end else if (pick < 58) begin
				rq.op = ric_pkg::OP_SET_PEND;
				if ($urandom_range(0, 3) != 0)
					rq.write_data = sparse_word();
			end else if (pick < 68) begin
				rq.op = ric_pkg::OP_CLR_PEND;
				if ($urandom_range(0, 3) != 0)
					rq.write_data = sparse_word();
			end else if (pick < 95) begin
				rq.op = ric_pkg::OP_FIND;
				k = $urandom_range(0, 9);
				if (k < 8)
					rq.index = ric_pkg::IDX_W'($urandom_range(0, NLINES - 1));
				else if (k == 8)
					rq.index = ric_pkg::IDX_W'($urandom_range(6, 15));
				else
					rq.index = ric_pkg::IDX_W'($urandom_range(16, 63));
			end else begin
				rq.op = pick[0] ? OP_SPARE_6 : OP_SPARE_7;
			end
			issue(rq, 1'b0, '0);
		end
		s_tvalid <= 1'b0;

		while (awaited_responses.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = quiet ? 0 : $urandom_range(0, MAX_WAIT);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			@(posedge clk);
			while (!m_tvalid) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			got_rsp.read_data = m_tdata[HARD_LO-1:0];
			got_rsp.hard_irq = m_tdata[FV_BIT-1:HARD_LO];
			got_rsp.found_valid = m_tdata[FV_BIT];
			got_rsp.found_source = m_tdata[FS_LO+ric_pkg::FOUND_W-1:FS_LO];
			if (awaited_responses.size() == 0) begin
				$error("result with no request outstanding: %h", m_tdata);
				error_count = error_count + 1;
			end else begin
				want_rsp = awaited_responses.pop_front();
				if (got_rsp.read_data !== want_rsp.read_data) begin
					$error("read_data: expected %h, got %h",
						want_rsp.read_data, got_rsp.read_data);
					error_count = error_count + 1;
				end
				if (got_rsp.hard_irq !== want_rsp.hard_irq) begin
					$error("hard_irq: expected %b, got %b",
						want_rsp.hard_irq, got_rsp.hard_irq);
					error_count = error_count + 1;
				end
				if (got_rsp.found_valid !== want_rsp.found_valid) begin
					$error("found_valid: expected %b, got %b",
						want_rsp.found_valid, got_rsp.found_valid);
					error_count = error_count + 1;
				end
				if (got_rsp.found_source !== want_rsp.found_source) begin
					$error("found_source: expected %0d, got %0d",
						want_rsp.found_source, got_rsp.found_source);
					error_count = error_count + 1;
				end
			end
		end
	end

	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count = cycle_count + 1;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// File: routed_interrupt_controller.f
src/ric_pkg.sv
src/ric_ctrl.sv
src/ric_dp.sv
src/routed_interrupt_controller.sv
verif/routed_interrupt_controller_tb.sv
